// File: rtl/core/b64png_pkg.sv
// Shared types, constants and functions for the Base64 PNG chunk validator.
package b64png_pkg;

    localparam logic [27:0] COUNT_MAX = 28'hFFF_FFFF;
    localparam logic [26:0] BYTES_MAX = 27'h7FF_FFFF;
    localparam logic [26:0] MIN_BYTES = 27'd33;
    localparam logic [26:0] SIG_BYTES = 27'd8;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // status codes
    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_TEXT_SIZE     = 4'd1;
    localparam logic [3:0] ST_PADDING       = 4'd2;
    localparam logic [3:0] ST_CHARACTER     = 4'd3;
    localparam logic [3:0] ST_NONCANON      = 4'd4;
    localparam logic [3:0] ST_NOT_PNG       = 4'd5;
    localparam logic [3:0] ST_TRUNC_CHUNK   = 4'd6;
    localparam logic [3:0] ST_TRUNC_PAYLOAD = 4'd7;
    localparam logic [3:0] ST_CRC           = 4'd8;
    localparam logic [3:0] ST_NO_HEADER     = 4'd9;
    localparam logic [3:0] ST_DIMENSIONS    = 4'd10;
    localparam logic [3:0] ST_REPEAT_HDR    = 4'd11;
    localparam logic [3:0] ST_BAD_END       = 4'd12;
    localparam logic [3:0] ST_MISSING_END   = 4'd13;

    // register indexes
    localparam logic [1:0] REG_MAX_BYTES  = 2'd0;
    localparam logic [1:0] REG_MAX_EDGE   = 2'd1;
    localparam logic [1:0] REG_MAX_PIXELS = 2'd2;

    localparam logic [26:0] RST_MAX_BYTES  = 27'd20971520;
    localparam logic [15:0] RST_MAX_EDGE   = 16'd32768;
    localparam logic [31:0] RST_MAX_PIXELS = 32'd32000000;

    localparam logic [31:0] KIND_IHDR = 32'h4948_4452;
    localparam logic [31:0] KIND_IDAT = 32'h4944_4154;
    localparam logic [31:0] KIND_IEND = 32'h4945_4E44;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [26:0] max_bytes;
        logic [15:0] max_edge;
        logic [31:0] max_pixels;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_beat_t;

    typedef struct packed {
        logic [27:0] char_count;
        logic [3:0]  text_error;
    } text_stat_t;

    typedef struct packed {
        logic [26:0] byte_count;
        logic        sig_ok;
        logic [3:0]  stream_error;
        logic [31:0] chunk_offset;
        logic        end_seen;
        logic [15:0] width;
        logic [15:0] height;
    } png_stat_t;

    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // bit 6 set when the character is in the alphabet
    function automatic logic [6:0] sextet(logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c inside {[8'h61:8'h7A]}) begin
            r = {1'b1, 6'(c - 8'h47)};
        end else if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 6'(c + 8'h04)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic logic [7:0] magic_byte(logic [2:0] i);
        logic [7:0] m;
        case (i)
            3'd0: m = 8'd137;
            3'd1: m = 8'd80;
            3'd2: m = 8'd78;
            3'd3: m = 8'd71;
            3'd4: m = 8'd13;
            3'd5: m = 8'd10;
            3'd6: m = 8'd26;
            default: m = 8'd10;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/b64png_decoder.sv
// Strict Base64 character decoder with canonical padding checks.
module b64png_decoder (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   take,
    input  logic                   clear,
    input  logic [7:0]             symbol,
    output b64png_pkg::byte_beat_t out_byte,
    output b64png_pkg::text_stat_t stat
);

    logic [27:0] cc_reg, cc_next;
    logic [1:0]  gpos_reg, gpos_next;
    logic [5:0]  gv0_reg, gv0_next, gv1_reg, gv1_next, gv2_reg, gv2_next;
    logic [1:0]  pad_reg, pad_next;
    logic        padded_reg, padded_next;
    logic [3:0]  terr_reg, terr_next;
    logic [6:0]  sx;
    logic [5:0]  g0, g1, g2;
    logic [1:0]  pad;
    logic        ok;

    assign sx = b64png_pkg::sextet(symbol);

    always_comb begin
        cc_next     = cc_reg;
        gpos_next   = gpos_reg;
        gv0_next    = gv0_reg;
        gv1_next    = gv1_reg;
        gv2_next    = gv2_reg;
        pad_next    = pad_reg;
        padded_next = padded_reg;
        terr_next   = terr_reg;
        out_byte    = '0;
        g0  = gv0_reg;
        g1  = gv1_reg;
        g2  = gv2_reg;
        pad = pad_reg;
        ok  = 1'b0;
        if (take) begin
            if (cc_reg != b64png_pkg::COUNT_MAX) begin
                cc_next = cc_reg + 28'd1;
            end
            if (terr_reg != b64png_pkg::ST_OK) begin
                ok = 1'b0;
            end else if (padded_reg) begin
                terr_next = b64png_pkg::ST_NONCANON;
            end else if (symbol == b64png_pkg::PAD_CHAR) begin
                if (gpos_reg < 2'd2) begin
                    terr_next = b64png_pkg::ST_PADDING;
                end else begin
                    ok  = 1'b1;
                    pad = pad_reg + 2'd1;
                    if (gpos_reg == 2'd2) begin
                        g2 = 6'd0;
                    end
                end
            end else if (pad_reg != 2'd0 || !sx[6]) begin
                terr_next = b64png_pkg::ST_CHARACTER;
            end else begin
                ok = 1'b1;
                case (gpos_reg)
                    2'd0: begin
                        g0 = sx[5:0];
                    end
                    2'd1: begin
                        g1 = sx[5:0];
                        out_byte = {1'b1, g0, sx[5:4]};
                    end
                    2'd2: begin
                        g2 = sx[5:0];
                        out_byte = {1'b1, g1[3:0], sx[5:2]};
                    end
                    default: begin
                        out_byte = {1'b1, g2[1:0], sx[5:0]};
                    end
                endcase
            end
            if (ok) begin
                if (gpos_reg == 2'd3) begin
                    if (pad == 2'd2 && g1[3:0] != 4'd0) begin
                        terr_next = b64png_pkg::ST_NONCANON;
                    end else if (pad == 2'd1 && g2[1:0] != 2'd0) begin
                        terr_next = b64png_pkg::ST_NONCANON;
                    end else if (pad != 2'd0) begin
                        padded_next = 1'b1;
                    end
                    pad_next  = 2'd0;
                    gpos_next = 2'd0;
                    gv0_next  = 6'd0;
                    gv1_next  = 6'd0;
                    gv2_next  = 6'd0;
                end else begin
                    pad_next  = pad;
                    gpos_next = gpos_reg + 2'd1;
                    gv0_next  = g0;
                    gv1_next  = g1;
                    gv2_next  = g2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            cc_reg     <= '0;
            gpos_reg   <= '0;
            gv0_reg    <= '0;
            gv1_reg    <= '0;
            gv2_reg    <= '0;
            pad_reg    <= '0;
            padded_reg <= 1'b0;
            terr_reg   <= b64png_pkg::ST_OK;
        end else begin
            cc_reg     <= cc_next;
            gpos_reg   <= gpos_next;
            gv0_reg    <= gv0_next;
            gv1_reg    <= gv1_next;
            gv2_reg    <= gv2_next;
            pad_reg    <= pad_next;
            padded_reg <= padded_next;
            terr_reg   <= terr_next;
        end
    end

    assign stat.char_count = cc_reg;
    assign stat.text_error = terr_reg;

endmodule

// File: rtl/core/b64png_chunk.sv
// PNG signature, chunk framing, CRC-32 and header checks on decoded bytes.
module b64png_chunk (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   clear,
    input  b64png_pkg::byte_beat_t in_byte,
    input  b64png_pkg::cfg_t       cfg,
    output b64png_pkg::png_stat_t  stat
);

    logic [26:0] bc_reg, bc_next, bc_inc;
    logic        sig_reg, sig_next;
    logic [31:0] ofs_reg, ofs_next, len_reg, len_next, kind_reg, kind_next;
    logic [31:0] crc_reg, crc_next, rcv_reg, rcv_next;
    logic        hdr_reg, hdr_next, pix_reg, pix_next, end_reg, end_next;
    logic [3:0]  serr_reg, serr_next, err;
    logic [31:0] w_reg, w_next, h_reg, h_next;
    logic [31:0] prod_reg, wa, ha;
    logic [32:0] ofs_ext, len_ext;
    logic [7:0]  b;

    assign b       = in_byte.data;
    assign bc_inc  = (bc_reg != b64png_pkg::BYTES_MAX) ? bc_reg + 27'd1 : bc_reg;
    assign ofs_ext = {1'b0, ofs_reg};
    assign len_ext = {1'b0, len_reg};
    // width times height is staged well before the header chunk ends
    assign wa      = {16'd0, w_reg[15:0]};
    assign ha      = {16'd0, h_reg[15:0]};

    always_comb begin
        bc_next   = bc_reg;
        sig_next  = sig_reg;
        ofs_next  = ofs_reg;
        len_next  = len_reg;
        kind_next = kind_reg;
        crc_next  = crc_reg;
        rcv_next  = rcv_reg;
        hdr_next  = hdr_reg;
        pix_next  = pix_reg;
        end_next  = end_reg;
        serr_next = serr_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        err       = b64png_pkg::ST_OK;
        if (in_byte.valid) begin
            bc_next = bc_inc;
            if (bc_reg < b64png_pkg::SIG_BYTES && b != b64png_pkg::magic_byte(bc_reg[2:0])) begin
                sig_next = 1'b0;
            end
            if (bc_inc > cfg.max_bytes || bc_reg < b64png_pkg::SIG_BYTES ||
                serr_reg != b64png_pkg::ST_OK) begin
                err = b64png_pkg::ST_OK;
            end else if (end_reg) begin
                serr_next = b64png_pkg::ST_BAD_END;
            end else begin
                if (ofs_reg < 32'd4) begin
                    len_next = {len_reg[23:0], b};
                end else if (ofs_reg < 32'd8) begin
                    kind_next = {kind_reg[23:0], b};
                    crc_next  = b64png_pkg::crc_byte(crc_reg, b);
                end else if (ofs_ext < len_ext + 33'd8) begin
                    crc_next = b64png_pkg::crc_byte(crc_reg, b);
                    if (!hdr_reg) begin
                        if (ofs_reg < 32'd12) begin
                            w_next = {w_reg[23:0], b};
                        end else if (ofs_reg < 32'd16) begin
                            h_next = {h_reg[23:0], b};
                        end
                    end
                end else begin
                    rcv_next = {rcv_reg[23:0], b};
                end
                ofs_next = ofs_reg + 32'd1;
                if (ofs_reg >= 32'd4 && ofs_ext + 33'd1 == len_ext + 33'd12) begin
                    if ((crc_next ^ b64png_pkg::CRC_INIT) != rcv_next) begin
                        err = b64png_pkg::ST_CRC;
                    end else if (!hdr_reg) begin
                        if (kind_next != b64png_pkg::KIND_IHDR || len_next != 32'd13) begin
                            err = b64png_pkg::ST_NO_HEADER;
                        end else begin
                            hdr_next = 1'b1;
                            if (w_next == 32'd0 || h_next == 32'd0 ||
                                w_next > {16'd0, cfg.max_edge} ||
                                h_next > {16'd0, cfg.max_edge} ||
                                prod_reg > cfg.max_pixels) begin
                                err = b64png_pkg::ST_DIMENSIONS;
                            end
                        end
                    end else if (kind_next == b64png_pkg::KIND_IHDR) begin
                        err = b64png_pkg::ST_REPEAT_HDR;
                    end
                    if (err == b64png_pkg::ST_OK) begin
                        if (kind_next == b64png_pkg::KIND_IDAT) begin
                            pix_next = 1'b1;
                        end
                        if (kind_next == b64png_pkg::KIND_IEND) begin
                            if (len_next != 32'd0 || !pix_reg) begin
                                err = b64png_pkg::ST_BAD_END;
                            end else begin
                                end_next = 1'b1;
                            end
                        end
                    end
                    serr_next = err;
                    ofs_next  = 32'd0;
                    len_next  = 32'd0;
                    kind_next = 32'd0;
                    crc_next  = b64png_pkg::CRC_INIT;
                    rcv_next  = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= wa * ha;
        if (!aresetn || clear) begin
            bc_reg   <= '0;
            sig_reg  <= 1'b1;
            ofs_reg  <= '0;
            len_reg  <= '0;
            kind_reg <= '0;
            crc_reg  <= b64png_pkg::CRC_INIT;
            rcv_reg  <= '0;
            hdr_reg  <= 1'b0;
            pix_reg  <= 1'b0;
            end_reg  <= 1'b0;
            serr_reg <= b64png_pkg::ST_OK;
            w_reg    <= '0;
            h_reg    <= '0;
        end else begin
            bc_reg   <= bc_next;
            sig_reg  <= sig_next;
            ofs_reg  <= ofs_next;
            len_reg  <= len_next;
            kind_reg <= kind_next;
            crc_reg  <= crc_next;
            rcv_reg  <= rcv_next;
            hdr_reg  <= hdr_next;
            pix_reg  <= pix_next;
            end_reg  <= end_next;
            serr_reg <= serr_next;
            w_reg    <= w_next;
            h_reg    <= h_next;
        end
    end

    assign stat.byte_count   = bc_reg;
    assign stat.sig_ok       = sig_reg;
    assign stat.stream_error = serr_reg;
    assign stat.chunk_offset = ofs_reg;
    assign stat.end_seen     = end_reg;
    assign stat.width        = w_reg[15:0];
    assign stat.height       = h_reg[15:0];

endmodule

// File: rtl/core/base64_png_chunk_validator_top.sv
// Top level: Base64 decode, PNG chunk validation and the result register.
// A decoded byte or a status beat is registered onto m_* in the cycle after
// the input is accepted. Throughput: one beat per cycle if m_* is free, set
// by the single decode, CRC update and check pass before the state registers.
// Reset (aresetn low, synchronous) clears all decode and chunk state, loads
// the register defaults and empties the result register. A status beat also
// returns all decode and chunk state to reset; register values are kept.
module base64_png_chunk_validator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] data_byte, [11:8] status,
                                   // [27:12] image_width, [43:28] image_height
    output logic        m_tuser,   // is_status
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    b64png_pkg::cfg_t       cfg_reg;
    b64png_pkg::byte_beat_t dec_byte;
    b64png_pkg::text_stat_t tstat;
    b64png_pkg::png_stat_t  pstat;

    logic        take_sym, take_end;
    logic        m_valid_reg, m_user_reg;
    logic [47:0] m_data_reg;
    logic [3:0]  final_st;
    logic [27:0] three_groups, size_limit;
    logic        size_bad;

    // the output register frees up whenever the downstream takes its beat
    assign s_tready = !m_valid_reg || m_tready;
    assign take_sym = s_tvalid && s_tready && !s_tlast;
    assign take_end = s_tvalid && s_tready && s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_bytes  <= b64png_pkg::RST_MAX_BYTES;
            cfg_reg.max_edge   <= b64png_pkg::RST_MAX_EDGE;
            cfg_reg.max_pixels <= b64png_pkg::RST_MAX_PIXELS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                b64png_pkg::REG_MAX_BYTES:  cfg_reg.max_bytes  <= cfg_wdata[26:0];
                b64png_pkg::REG_MAX_EDGE:   cfg_reg.max_edge   <= cfg_wdata[15:0];
                b64png_pkg::REG_MAX_PIXELS: cfg_reg.max_pixels <= cfg_wdata;
                default: ;
            endcase
        end
    end

    b64png_decoder u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take_sym),
        .clear    (take_end),
        .symbol   (s_tdata),
        .out_byte (dec_byte),
        .stat     (tstat)
    );

    b64png_chunk u_chunk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (take_end),
        .in_byte (dec_byte),
        .cfg     (cfg_reg),
        .stat    (pstat)
    );

    // text limit: groups*3 must not exceed max_bytes + 2
    assign three_groups = {2'b00, tstat.char_count[27:2]} + {1'b0, tstat.char_count[27:2], 1'b0};
    assign size_limit   = {1'b0, cfg_reg.max_bytes} + 28'd2;
    assign size_bad     = tstat.char_count == 28'd0 || tstat.char_count[1:0] != 2'd0 ||
                          three_groups > size_limit;

    // first error wins, in priority order
    always_comb begin
        if (size_bad) begin
            final_st = b64png_pkg::ST_TEXT_SIZE;
        end else if (tstat.text_error != b64png_pkg::ST_OK) begin
            final_st = tstat.text_error;
        end else if (pstat.byte_count > cfg_reg.max_bytes ||
                     pstat.byte_count < b64png_pkg::MIN_BYTES || !pstat.sig_ok) begin
            final_st = b64png_pkg::ST_NOT_PNG;
        end else if (pstat.stream_error != b64png_pkg::ST_OK) begin
            final_st = pstat.stream_error;
        end else if (pstat.chunk_offset != 32'd0) begin
            final_st = (pstat.chunk_offset < 32'd12) ? b64png_pkg::ST_TRUNC_CHUNK
                                                     : b64png_pkg::ST_TRUNC_PAYLOAD;
        end else if (!pstat.end_seen) begin
            final_st = b64png_pkg::ST_MISSING_END;
        end else begin
            final_st = b64png_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take_end || (take_sym && dec_byte.valid)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (take_end) begin
            m_user_reg <= 1'b1;
            if (final_st == b64png_pkg::ST_OK) begin
                m_data_reg <= {4'd0, pstat.height, pstat.width, final_st, 8'd0};
            end else begin
                m_data_reg <= {36'd0, final_st, 8'd0};
            end
        end else if (take_sym && dec_byte.valid) begin
            m_user_reg <= 1'b0;
            m_data_reg <= {40'd0, dec_byte.data};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/core/b64png_props.sv
// Port-level assertions for the validator, bound to the top level.
module b64png_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_byte_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[47:8] == 40'd0)
        else $error("byte beat carries status fields");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0 && m_tdata[11:8] <= 4'd13)
        else $error("bad status beat");

    a_dims_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && m_tdata[11:8] != 4'd0 |-> m_tdata[43:12] == 32'd0)
        else $error("dimensions reported with an error status");

endmodule

bind base64_png_chunk_validator_top b64png_props u_props (.*);
